FILE: design/cir_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cir_pkg: shared definitions for the cubic interpolating resampler
// Widths, constants, control types and small arithmetic helpers that the
// interfaces, controller, datapath and top level all use.
// ----------------------------------------------------------------------------
package cir_pkg;

    // Sample and phase formats.
    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = 14;
    localparam int MAX_CHANNELS = 2;
    localparam int HIST_FRAMES  = 6;
    localparam int MAX_RESULTS  = 4;

    // Configuration register widths and limits (step is unsigned Q3.14).
    localparam int STEP_W      = 17;
    localparam int CH_W        = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 17;
    localparam int STEP_MIN    = 4096;
    localparam int STEP_MAX    = 65536;
    localparam int STEP_RESET  = 16384;
    localparam int CH_RESET    = 2;
    localparam int STEP_FB     = 14;
    localparam int STEP_LSH    = (FRAC_BITS >= STEP_FB) ? FRAC_BITS - STEP_FB : 0;
    localparam int STEP_RSH    = (FRAC_BITS >= STEP_FB) ? 0 : STEP_FB - FRAC_BITS;

    // Read position: fraction plus up to four whole frames of advance.
    localparam int POS_W       = FRAC_BITS + 3;
    localparam int WHOLE_W     = POS_W - FRAC_BITS;
    localparam int PEND_W      = $clog2(HIST_FRAMES + 1);
    localparam int RUN_W       = $clog2(MAX_RESULTS);
    localparam int WIN_W       = 2;
    localparam int NEED_WHOLE  = 4;
    localparam int NEED_FRAC   = 5;
    localparam int K0_MIN      = 3;
    localparam int K0_MAX      = HIST_FRAMES - 1;

    // Datapath widths for the Horner evaluation.
    localparam int COEF_W = SAMPLE_BITS + 4;
    localparam int T_W    = SAMPLE_BITS + 6;
    localparam int FOP_W  = FRAC_BITS + 1;
    localparam int PROD_W = T_W + FOP_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int V_W    = ACC_W - FRAC_BITS - 1;

    localparam logic signed [ACC_W-1:0] RND_T = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] RND_V = ACC_W'(1) << FRAC_BITS;
    localparam logic signed [V_W-1:0]   SAT_HI =
        V_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [V_W-1:0]   SAT_LO = ~SAT_HI;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_RATIO    = 1'b0,
        REG_CHANNEL_COUNT = 1'b1
    } cir_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_LOAD,
        S_MUL1,
        S_ADD1,
        S_MUL2,
        S_ADD2,
        S_MUL3,
        S_FIN
    } cir_state_t;

    typedef enum logic {
        MUL_SRC_A,
        MUL_SRC_T
    } cir_mul_src_t;

    typedef enum logic {
        ADD_B,
        ADD_C
    } cir_add_sel_t;

    typedef struct packed {
        logic         hist_shift;
        logic         coef_load;
        logic         mul_en;
        cir_mul_src_t mul_src;
        logic         add_en;
        cir_add_sel_t add_sel;
        logic         fin_load;
        logic         fin_last;
    } cir_cmd_t;

    typedef struct packed {
        logic emit_ok;
        logic next_emit_ok;
    } cir_sts_t;

    function automatic logic [POS_W-1:0] eff_step(input logic [STEP_W-1:0] s);
        logic [STEP_W-1:0]           c;
        logic [STEP_W+FRAC_BITS-1:0] w;
        c = s;
        if (c < STEP_W'(STEP_MIN))
            c = STEP_W'(STEP_MIN);
        if (c > STEP_W'(STEP_MAX))
            c = STEP_W'(STEP_MAX);
        w = {{FRAC_BITS{1'b0}}, c};
        w = (w << STEP_LSH) >> STEP_RSH;
        return w[POS_W-1:0];
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_ext(input sample_t s);
        return {{(COEF_W - SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
    endfunction

    function automatic sample_t saturate(input logic signed [V_W-1:0] v);
        logic signed [V_W-1:0] c;
        c = v;
        if (c > SAT_HI)
            c = SAT_HI;
        if (c < SAT_LO)
            c = SAT_LO;
        return c[SAMPLE_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/cir_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cir_ifs: channel interfaces of the cubic interpolating resampler
// Input frame channel, result channel and configuration write channel,
// each a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface cir_sample_if;
    import cir_pkg::*;
    logic    valid;
    logic    ready;
    sample_t left_sample;
    sample_t right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface cir_result_if;
    import cir_pkg::*;
    logic    valid;
    logic    ready;
    sample_t left_out;
    sample_t right_out;
    logic    last_of_run;

    modport source (output valid, output left_out, output right_out, output last_of_run,
                    input ready);
    modport sink   (input valid, input left_out, input right_out, input last_of_run,
                    output ready);
endinterface

interface cir_cfg_if;
    import cir_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: design/cir_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cir_datapath: history, read position and Horner evaluation lanes
// Holds the frame history and read position, and evaluates the cubic for
// every channel lane with one multiplier and one adder per lane.
// ----------------------------------------------------------------------------
module cir_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cir_pkg::cir_cmd_t           cmd,
    output cir_pkg::cir_sts_t                sts,
    input  wire logic [cir_pkg::STEP_W-1:0]  step_ratio,
    input  wire logic                        mono,
    input  wire cir_pkg::sample_t            left_sample,
    input  wire cir_pkg::sample_t            right_sample,
    output cir_pkg::sample_t                 left_out,
    output cir_pkg::sample_t                 right_out,
    output logic                             last_of_run
);
    import cir_pkg::*;

    sample_t hist_reg  [HIST_FRAMES][MAX_CHANNELS];
    sample_t hist_next [HIST_FRAMES][MAX_CHANNELS];

    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [PEND_W-1:0]    pend_reg, pend_next;
    logic                 adv_reg, adv_next;

    logic signed [COEF_W-1:0] a_reg [MAX_CHANNELS];
    logic signed [COEF_W-1:0] b_reg [MAX_CHANNELS];
    logic signed [COEF_W-1:0] c_reg [MAX_CHANNELS];
    logic signed [COEF_W-1:0] y1_reg [MAX_CHANNELS];
    logic signed [PROD_W-1:0] prod_reg [MAX_CHANNELS];
    logic signed [T_W-1:0]    t_reg [MAX_CHANNELS];
    sample_t                  left_reg, right_reg;
    logic                     last_reg;

    logic signed [COEF_W-1:0] e0 [MAX_CHANNELS];
    logic signed [COEF_W-1:0] e1 [MAX_CHANNELS];
    logic signed [COEF_W-1:0] e2 [MAX_CHANNELS];
    logic signed [COEF_W-1:0] e3 [MAX_CHANNELS];
    logic signed [COEF_W-1:0] a_next [MAX_CHANNELS];
    logic signed [COEF_W-1:0] b_next [MAX_CHANNELS];
    logic signed [COEF_W-1:0] c_next [MAX_CHANNELS];
    logic signed [PROD_W-1:0] prod_next [MAX_CHANNELS];
    logic signed [T_W-1:0]    t_next [MAX_CHANNELS];
    sample_t                  v_lane [MAX_CHANNELS];

    logic signed [PROD_W-1:0] mop_x [MAX_CHANNELS];
    logic signed [PROD_W-1:0] fop_x;
    logic signed [ACC_W-1:0]  prod_x [MAX_CHANNELS];
    logic signed [ACC_W-1:0]  add_x [MAX_CHANNELS];
    logic signed [ACC_W-1:0]  acc_t [MAX_CHANNELS];
    logic signed [ACC_W-1:0]  acc_v [MAX_CHANNELS];
    logic signed [COEF_W-1:0] addend [MAX_CHANNELS];

    logic [PEND_W-1:0]  k0;
    logic [WIN_W-1:0]   win;
    logic [POS_W-1:0]   pos_sum;
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_BITS-1:0] frac_adv;
    logic [PEND_W-1:0]  pend_adv;

    // Oldest tap of the four-frame window, relative to the newest frame.
    always_comb
    begin
        k0 = adv_reg ? pend_reg : pend_reg - PEND_W'(1);
        if (k0 > PEND_W'(K0_MAX))
            k0 = PEND_W'(K0_MAX);
        if (k0 < PEND_W'(K0_MIN))
            k0 = PEND_W'(K0_MIN);
        win = WIN_W'(k0 - PEND_W'(K0_MIN));
    end

    // Position after one more result.
    always_comb
    begin
        pos_sum  = {{(POS_W - FRAC_BITS){1'b0}}, frac_reg} + eff_step(step_ratio);
        whole    = pos_sum[POS_W-1:FRAC_BITS];
        frac_adv = pos_sum[FRAC_BITS-1:0];
        pend_adv = pend_reg;
        if (whole != '0)
        begin
            if (PEND_W'(whole) >= pend_reg)
                pend_adv = '0;
            else
                pend_adv = pend_reg - PEND_W'(whole);
        end
    end

    always_comb
    begin
        sts.emit_ok = (frac_reg == '0) ? (pend_reg >= PEND_W'(NEED_WHOLE))
                                       : (pend_reg >= PEND_W'(NEED_FRAC));
        sts.next_emit_ok = (frac_adv == '0) ? (pend_adv >= PEND_W'(NEED_WHOLE))
                                            : (pend_adv >= PEND_W'(NEED_FRAC));
    end

    // Lane arithmetic: window taps, coefficients, multiply and accumulate.
    always_comb
    begin
        fop_x = {{(PROD_W - FOP_W + 1){1'b0}}, frac_reg};
        for (int ln = 0; ln < MAX_CHANNELS; ln++)
        begin
            case (win)
                2'd0:
                begin
                    e0[ln] = coef_ext(hist_reg[3][ln]);
                    e1[ln] = coef_ext(hist_reg[2][ln]);
                    e2[ln] = coef_ext(hist_reg[1][ln]);
                    e3[ln] = coef_ext(hist_reg[0][ln]);
                end
                2'd1:
                begin
                    e0[ln] = coef_ext(hist_reg[4][ln]);
                    e1[ln] = coef_ext(hist_reg[3][ln]);
                    e2[ln] = coef_ext(hist_reg[2][ln]);
                    e3[ln] = coef_ext(hist_reg[1][ln]);
                end
                default:
                begin
                    e0[ln] = coef_ext(hist_reg[5][ln]);
                    e1[ln] = coef_ext(hist_reg[4][ln]);
                    e2[ln] = coef_ext(hist_reg[3][ln]);
                    e3[ln] = coef_ext(hist_reg[2][ln]);
                end
            endcase

            a_next[ln] = e3[ln] - e0[ln] + (e1[ln] <<< 1) + e1[ln]
                         - (e2[ln] <<< 1) - e2[ln];
            b_next[ln] = (e0[ln] <<< 1) - (e1[ln] <<< 2) - e1[ln]
                         + (e2[ln] <<< 2) - e3[ln];
            c_next[ln] = e2[ln] - e0[ln];

            if (cmd.mul_src == MUL_SRC_A)
                mop_x[ln] = {{(PROD_W - COEF_W){a_reg[ln][COEF_W-1]}}, a_reg[ln]};
            else
                mop_x[ln] = {{(PROD_W - T_W){t_reg[ln][T_W-1]}}, t_reg[ln]};
            prod_next[ln] = mop_x[ln] * fop_x;

            addend[ln] = (cmd.add_sel == ADD_B) ? b_reg[ln] : c_reg[ln];
            prod_x[ln] = {{(ACC_W - PROD_W){prod_reg[ln][PROD_W-1]}}, prod_reg[ln]};
            add_x[ln]  = {{(ACC_W - COEF_W){addend[ln][COEF_W-1]}}, addend[ln]};
            acc_t[ln]  = prod_x[ln] + (add_x[ln] <<< FRAC_BITS) + RND_T;
            t_next[ln] = acc_t[ln][FRAC_BITS +: T_W];

            acc_v[ln]  = prod_x[ln] + RND_V
                         + ({{(ACC_W - COEF_W){y1_reg[ln][COEF_W-1]}}, y1_reg[ln]}
                            <<< (FRAC_BITS + 1));
            v_lane[ln] = saturate(acc_v[ln][FRAC_BITS + 1 +: V_W]);
        end
    end

    // History shift and read position.
    always_comb
    begin
        hist_next = hist_reg;
        frac_next = frac_reg;
        pend_next = pend_reg;
        adv_next  = adv_reg;
        if (cmd.hist_shift)
        begin
            for (int fr = HIST_FRAMES - 1; fr > 0; fr--)
                hist_next[fr] = hist_reg[fr - 1];
            hist_next[0][0] = left_sample;
            if (MAX_CHANNELS > 1)
                hist_next[0][MAX_CHANNELS - 1] = right_sample;
            if (pend_reg < PEND_W'(HIST_FRAMES))
                pend_next = pend_reg + PEND_W'(1);
        end
        if (cmd.fin_load)
        begin
            frac_next = frac_adv;
            pend_next = pend_adv;
            if (whole != '0)
                adv_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int fr = 0; fr < HIST_FRAMES; fr++)
                for (int ln = 0; ln < MAX_CHANNELS; ln++)
                    hist_reg[fr][ln] <= '0;
            frac_reg <= '0;
            pend_reg <= '0;
            adv_reg  <= 1'b0;
        end
        else
        begin
            hist_reg <= hist_next;
            frac_reg <= frac_next;
            pend_reg <= pend_next;
            adv_reg  <= adv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int ln = 0; ln < MAX_CHANNELS; ln++)
        begin
            if (cmd.coef_load)
            begin
                a_reg[ln]  <= a_next[ln];
                b_reg[ln]  <= b_next[ln];
                c_reg[ln]  <= c_next[ln];
                y1_reg[ln] <= e1[ln];
            end
            if (cmd.mul_en)
                prod_reg[ln] <= prod_next[ln];
            if (cmd.add_en)
                t_reg[ln] <= t_next[ln];
        end
        if (cmd.fin_load)
        begin
            left_reg  <= v_lane[0];
            right_reg <= (MAX_CHANNELS > 1 && !mono) ? v_lane[MAX_CHANNELS - 1] : '0;
            last_reg  <= cmd.fin_last;
        end
    end

    assign left_out    = left_reg;
    assign right_out   = right_reg;
    assign last_of_run = last_reg;

    // A result that moves the position by a whole frame leaves the start-of-stream
    // clamp behind for good.
    a_adv_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fin_load && whole != '0) |=> adv_reg)
        else $error("integer advance flag not set after whole-frame step");

endmodule
`default_nettype wire

FILE: design/cir_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cir_ctrl: sequencer of the cubic interpolating resampler
// Accepts frames, steps the datapath through each Horner evaluation and
// owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module cir_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire cir_pkg::cir_sts_t sts,
    output cir_pkg::cir_cmd_t      cmd
);
    import cir_pkg::*;

    cir_state_t       state_reg, state_next;
    logic [RUN_W-1:0] run_cnt_reg, run_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            run_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_cnt_reg   <= run_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        run_cnt_next = run_cnt_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.mul_src  = MUL_SRC_A;
        cmd.add_sel  = ADD_B;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.hist_shift = 1'b1;
                    run_cnt_next   = '0;
                    state_next     = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = sts.emit_ok ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                cmd.coef_load = 1'b1;
                state_next    = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MUL_SRC_A;
                state_next  = S_ADD1;
            end
            S_ADD1:
            begin
                cmd.add_en  = 1'b1;
                cmd.add_sel = ADD_B;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MUL_SRC_T;
                state_next  = S_ADD2;
            end
            S_ADD2:
            begin
                cmd.add_en  = 1'b1;
                cmd.add_sel = ADD_C;
                state_next  = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MUL_SRC_T;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin_last = !sts.next_emit_ok
                               || (run_cnt_reg == RUN_W'(MAX_RESULTS - 1));
                if (out_free)
                begin
                    cmd.fin_load = 1'b1;
                    if (cmd.fin_last)
                        state_next = S_IDLE;
                    else
                    begin
                        run_cnt_next = run_cnt_reg + RUN_W'(1);
                        state_next   = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.fin_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_load |-> (!out_valid_reg || out_ready))
        else $error("result register loaded while holding an untaken word");

    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> sts.emit_ok)
        else $error("evaluation started without enough frames");

    a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fin_load && run_cnt_reg == RUN_W'(MAX_RESULTS - 1)) |-> cmd.fin_last)
        else $error("run exceeded the result limit without a last mark");

endmodule
`default_nettype wire

FILE: design/cubic_interpolating_resampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_interpolating_resampler: Catmull-Rom cubic audio resampler
// Keeps six frames of history and a fractional read position, and emits
// interpolated, saturated Q1.15 frames as the position advances by the
// programmed step ratio.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake       Word contents
//  -------   ---------  --------------  ---------------------------------------
//  samples   in         valid / ready   left_sample, right_sample (Q1.15)
//  results   out        valid / ready   left_out, right_out, last_of_run
//  cfg       in         valid / ready   index (0 step_ratio, 1 channel_count), data
//
// Each input frame passes the accept and check states and then, for each of
// the n (0 to 4) results it produces, the seven-step Horner sequence on the
// one multiplier per channel lane; no new frame is taken until it is done.
// The result register holds one word; a frame may be accepted while the last
// result of the previous frame still waits there, and the final step of an
// evaluation waits while that register is full.
// Reset clears the history, the read position and the sequencer, and sets
// step_ratio to 1.0 and channel_count to stereo. The cfg channel is always
// ready and its writes take effect on the next cycle.
// ----------------------------------------------------------------------------
module cubic_interpolating_resampler (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cir_sample_if.sink    samples,
    cir_result_if.source  results,
    cir_cfg_if.sink       cfg
);
    import cir_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [CH_W-1:0]   chan_reg, chan_next;
    logic              mono;

    cir_cmd_t cmd;
    cir_sts_t sts;

    // Configuration registers. The user must issue writes only while the block
    // is idle, which the block does not enforce; writes are taken every cycle without further checks.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        step_next = step_reg;
        chan_next = chan_reg;
        if (cfg.valid)
        begin
            case (cir_reg_t'(cfg.index))
                REG_STEP_RATIO:    step_next = cfg.data[STEP_W-1:0];
                REG_CHANNEL_COUNT: chan_next = cfg.data[CH_W-1:0];
                default:
                begin
                    step_next = step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_W'(STEP_RESET);
            chan_reg <= CH_W'(CH_RESET);
        end
        else
        begin
            step_reg <= step_next;
            chan_reg <= chan_next;
        end
    end

    // A channel count of zero or one, or a single-lane build, means mono:
    // the right result is then forced to zero.
    assign mono = (MAX_CHANNELS < 2) || (chan_reg < CH_W'(2));

    cir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cir_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .step_ratio   (step_reg),
        .mono         (mono),
        .left_sample  (samples.left_sample),
        .right_sample (samples.right_sample),
        .left_out     (results.left_out),
        .right_out    (results.right_out),
        .last_of_run  (results.last_of_run)
    );

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the cubic interpolating resampler
// Feeds stereo audio frames and configuration writes into the block, predicts
// every interpolated output word with a fixed-point Catmull-Rom model kept in
// the bench, and checks each output word field by field, in order, under
// random idling on both handshakes.
// ----------------------------------------------------------------------------
module tb;
    import cir_pkg::*;

    // Bounds of a Q1.15 sample and a few step ratios in Q3.14.
    localparam int SMP_MAX       = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SMP_MIN       = -(1 << (SAMPLE_BITS - 1));
    localparam int STEP_ONE_HALF = STEP_RESET + STEP_RESET / 2;
    localparam int STEP_FULL     = (1 << STEP_W) - 1;

    // Idle time enough for a frame with no output, or one with four, to finish
    // in the block before a register write.
    localparam int SETTLE_CYCLES = 40;
    // Worst case is roughly 430 words times four outputs, each held up by the
    // longest sink stall, plus source gaps and settle pauses: well under the limit.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_FRAMES  = 50;

    // One output word as the block should deliver it.
    typedef struct packed {
        sample_t left_out;
        sample_t right_out;
        logic    last_of_run;
    } resampled_t;

    logic clk;
    logic rst_n;

    cir_sample_if smp ();
    cir_result_if res ();
    cir_cfg_if    cfg_ch ();

    cubic_interpolating_resampler i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (smp),
        .results (res),
        .cfg     (cfg_ch)
    );

    // Output words that the block still owes us, oldest first.
    resampled_t resampled_q[$];
    int         fail_count     = 0;
    int         src_gap_pct    = 10;
    int         sink_stall_pct = 10;

    // Bench copy of the block state: the six newest frames (newest at index
    // 0), the fraction of the read position, the distance in frames between
    // the newest frame and floor of the read position, and a flag that is set
    // once the read position has left frame zero.
    sample_t                hist_l[HIST_FRAMES];
    sample_t                hist_r[HIST_FRAMES];
    logic [FRAC_BITS-1:0]   pos_frac;
    logic [PEND_W-1:0]      lag;
    bit                     past_start;
    logic [STEP_W-1:0]      step_reg;
    logic [CH_W-1:0]        chan_reg;

    sample_t prev_l;
    sample_t prev_r;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The run is bounded by a plain cycle count. If the bench ever hangs on a
    // handshake or waits on words that never arrive, this ends it as a fail.
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb failed");
        $finish;
    end

    // Catmull-Rom cubic through y0..y3 at fraction f, in Horner form with the
    // doubled coefficients. Each shift rounds to nearest with ties going up,
    // which is an arithmetic shift of the value plus one half.
    function automatic sample_t catmull(input longint y0, input longint y1,
                                        input longint y2, input longint y3,
                                        input longint f);
        longint one;
        longint a;
        longint b;
        longint c;
        longint t1;
        longint t2;
        longint v;
        one = longint'(1) << FRAC_BITS;
        a   = -y0 + 3 * y1 - 3 * y2 + y3;
        b   = 2 * y0 - 5 * y1 + 4 * y2 - y3;
        c   = y2 - y0;
        t1  = (a * f + b * one + (one >>> 1)) >>> FRAC_BITS;
        t2  = (t1 * f + c * one + (one >>> 1)) >>> FRAC_BITS;
        v   = (2 * y1 * one + t2 * f + one) >>> (FRAC_BITS + 1);
        if (v > SMP_MAX)
            v = longint'(SMP_MAX);
        if (v < SMP_MIN)
            v = longint'(SMP_MIN);
        return sample_t'(v);
    endfunction

    // Works out every output word that one accepted frame causes and queues
    // them. The position check, the window choice and the advance follow the
    // block's behavior step by step.
    function automatic void resample_frame(input sample_t l, input sample_t r);
        resampled_t       run[MAX_RESULTS];
        resampled_t       word;
        logic [POS_W-1:0] step_eff;
        logic [POS_W-1:0] pos_next;
        int               lanes;
        int               need;
        int               k0;
        int               whole;
        int               n;
        bit               more;

        // Out-of-range settings are clamped, never rejected.
        step_eff = step_reg;
        if (step_reg < STEP_MIN)
            step_eff = POS_W'(STEP_MIN);
        if (step_reg > STEP_MAX)
            step_eff = POS_W'(STEP_MAX);
        lanes = int'(chan_reg);
        if (lanes < 1)
            lanes = 1;
        if (lanes > MAX_CHANNELS)
            lanes = MAX_CHANNELS;

        // Both channels are stored even in mono.
        for (int i = HIST_FRAMES - 1; i > 0; i--)
        begin
            hist_l[i] = hist_l[i-1];
            hist_r[i] = hist_r[i-1];
        end
        hist_l[0] = l;
        hist_r[0] = r;
        if (lag < HIST_FRAMES)
            lag++;

        n    = 0;
        more = 1'b1;
        while (more && n < MAX_RESULTS)
        begin
            // P + 4 <= T: four frames ahead on a whole position, five on a
            // fractional one.
            need = (pos_frac == 0) ? NEED_WHOLE : NEED_FRAC;
            if (lag < need)
                more = 1'b0;
            else
            begin
                // Until the position leaves frame zero the window base is
                // held at one, so the oldest of the four frames is one further.
                k0 = past_start ? int'(lag) : int'(lag) - 1;
                if (k0 > K0_MAX)
                    k0 = K0_MAX;
                if (k0 < K0_MIN)
                    k0 = K0_MIN;
                word.left_out    = catmull(longint'(hist_l[k0]), longint'(hist_l[k0-1]),
                                           longint'(hist_l[k0-2]), longint'(hist_l[k0-3]),
                                           longint'(pos_frac));
                word.right_out   = '0;
                if (lanes > 1)
                    word.right_out = catmull(longint'(hist_r[k0]), longint'(hist_r[k0-1]),
                                             longint'(hist_r[k0-2]),
                                             longint'(hist_r[k0-3]), longint'(pos_frac));
                word.last_of_run = 1'b0;
                run[n] = word;
                n++;

                pos_next = pos_frac + step_eff;
                whole    = int'(pos_next >> FRAC_BITS);
                pos_frac = pos_next[FRAC_BITS-1:0];
                if (whole > 0)
                begin
                    past_start = 1'b1;
                    lag        = (whole >= lag) ? '0 : PEND_W'(int'(lag) - whole);
                end
            end
        end

        if (n > 0)
        begin
            word             = run[n-1];
            word.last_of_run = 1'b1;
            run[n-1]         = word;
        end
        for (int i = 0; i < n; i++)
            resampled_q.push_back(run[i]);
    endfunction

    function automatic void report(input string msg);
        $display("%0t: %s", $time, msg);
        fail_count++;
    endfunction

    // Compares one accepted output word with the oldest one owed.
    function automatic void check_word(input sample_t l, input sample_t r,
                                       input logic last);
        resampled_t want;
        if (resampled_q.size() == 0)
            report($sformatf("output word expected none, got left %0d right %0d last %0b",
                             l, r, last));
        else
        begin
            want = resampled_q.pop_front();
            if (want.left_out !== l)
                report($sformatf("left_out expected %0d, got %0d",
                                 $signed(want.left_out), l));
            if (want.right_out !== r)
                report($sformatf("right_out expected %0d, got %0d",
                                 $signed(want.right_out), r));
            if (want.last_of_run !== last)
                report($sformatf("last_of_run expected %0b, got %0b",
                                 want.last_of_run, last));
        end
    endfunction

    // Every word that crosses the output handshake is checked at the edge
    // that moves it. Values read here are the ones present at that edge.
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            check_word(res.left_out, res.right_out, res.last_of_run);
    end

    // Output side: ready drops in random bursts at a rate that the
    // running test sets; a rate of zero leaves ready high throughout.
    initial
    begin
        res.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Sends one frame, maybe after a source gap, and runs the prediction at
    // the edge where it is accepted. Valid is left high so that a following
    // frame can go out back to back; whoever stops sending lowers it.
    task automatic feed_frame(input int l_val, input int r_val);
        sample_t l;
        sample_t r;
        l = sample_t'(l_val);
        r = sample_t'(r_val);
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct)
        begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        smp.valid        <= 1'b1;
        smp.left_sample  <= l;
        smp.right_sample <= r;
        do @(posedge clk); while (!smp.ready);
        resample_frame(l, r);
    endtask

    // Stops the frame stream and waits until every owed word has arrived,
    // then lets a frame that causes no output finish inside the block.
    task automatic drain;
        smp.valid <= 1'b0;
        while (resampled_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers back to back; only called while the block idles.
    task automatic set_config(input int step_val, input int ch_val);
        logic [CFG_DATA_W-1:0] step_word;
        logic [CFG_DATA_W-1:0] ch_word;
        step_word = CFG_DATA_W'(step_val);
        ch_word   = CFG_DATA_W'(ch_val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_STEP_RATIO;
        cfg_ch.data  <= step_word;
        do @(posedge clk); while (!cfg_ch.ready);
        step_reg = step_word[STEP_W-1:0];
        cfg_ch.index <= REG_CHANNEL_COUNT;
        cfg_ch.data  <= ch_word;
        do @(posedge clk); while (!cfg_ch.ready);
        chan_reg = ch_word[CH_W-1:0];
        cfg_ch.valid <= 1'b0;
    endtask

    // Random audio: a mix of full-scale extremes, white noise and a smooth
    // walk, so that both saturating and ordinary interpolation get exercised.
    function automatic sample_t next_sample(input sample_t prev);
        int v;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = SMP_MIN;
                    1:       v = SMP_MAX;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            1, 2, 3: v = int'(sample_t'($urandom));
            default:
            begin
                v = int'(prev) + int'($urandom_range(0, 4096)) - 2048;
                if (v > SMP_MAX)
                    v = SMP_MAX;
                if (v < SMP_MIN)
                    v = SMP_MIN;
            end
        endcase
        return sample_t'(v);
    endfunction

    function automatic int pick_idle_pct;
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            2:       return 10;
            default: return 25;
        endcase
    endfunction

    // Reset defaults (step 1.0, stereo) with full-scale words straight out of
    // reset. The first outputs come while the window base is still held at
    // frame one, and each needs four frames ahead of a whole position.
    task automatic test_start_of_stream;
        feed_frame(SMP_MAX, SMP_MIN);
        feed_frame(SMP_MIN, SMP_MAX);
        feed_frame(0, -1);
        feed_frame(-1, 0);
        feed_frame(SMP_MAX, SMP_MAX);
        feed_frame(SMP_MIN, SMP_MIN);
    endtask

    // Slowest step gives four outputs per frame at quarter positions; the
    // alternating full-scale pattern drives the cubic past both rails. The
    // fastest step then skips four frames per output.
    task automatic test_step_extremes;
        drain();
        set_config(STEP_MIN, 2);
        feed_frame(SMP_MIN, SMP_MAX);
        feed_frame(SMP_MAX, SMP_MIN);
        feed_frame(SMP_MAX, SMP_MIN);
        feed_frame(SMP_MIN, SMP_MAX);
        drain();
        set_config(STEP_MAX, 2);
        feed_frame(SMP_MAX, 0);
        feed_frame(0, SMP_MAX);
        feed_frame(SMP_MIN, -1);
        feed_frame(-1, SMP_MIN);
        feed_frame(SMP_MAX, SMP_MAX);
    endtask

    // Values outside the legal ranges are clamped: an all-ones step acts as
    // 4.0, a zero step as 0.25, a channel count of zero as mono and of three
    // as stereo. Switching channel count keeps history and position. The
    // step of 1.5 alternates whole and half positions, so readiness flips
    // between needing four and five frames ahead.
    task automatic test_clamped_config;
        drain();
        set_config(STEP_FULL, 0);
        feed_frame(SMP_MAX, SMP_MIN);
        feed_frame(SMP_MIN, SMP_MAX);
        drain();
        set_config(0, 3);
        feed_frame(SMP_MIN, SMP_MIN);
        feed_frame(SMP_MAX, SMP_MAX);
        drain();
        set_config(STEP_ONE_HALF, 1);
        feed_frame(SMP_MIN, SMP_MAX);
        feed_frame(SMP_MAX, SMP_MIN);
        feed_frame(0, 0);
    endtask

    // Phases of random audio, each under its own register setting and idle
    // rates. The last phase runs with no idling on either side.
    task automatic test_random_streams;
        logic [CFG_DATA_W-1:0] step_word;
        logic [CFG_DATA_W-1:0] ch_word;
        sample_t               l;
        sample_t               r;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            case ($urandom_range(0, 5))
                0:       step_word = CFG_DATA_W'(STEP_MIN);
                1:       step_word = CFG_DATA_W'(STEP_MAX);
                2:       step_word = CFG_DATA_W'($urandom_range(0, STEP_FULL));
                3:       step_word = CFG_DATA_W'(STEP_RESET / 2 * $urandom_range(1, 8));
                default: step_word = CFG_DATA_W'($urandom_range(STEP_MIN, STEP_MAX));
            endcase
            // Upper data bits of the channel register are random; only the
            // low bits count.
            ch_word = CFG_DATA_W'($urandom);
            case ($urandom_range(0, 5))
                0:       ch_word[CH_W-1:0] = 2'd0;
                1:       ch_word[CH_W-1:0] = 2'd3;
                2, 3:    ch_word[CH_W-1:0] = 2'd1;
                default: ch_word[CH_W-1:0] = 2'd2;
            endcase
            set_config(int'(step_word), int'(ch_word));
            if (ph == RANDOM_PHASES - 1)
            begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            else
            begin
                src_gap_pct    = pick_idle_pct();
                sink_stall_pct = pick_idle_pct();
            end
            repeat (PHASE_FRAMES)
            begin
                l = next_sample(prev_l);
                r = next_sample(prev_r);
                feed_frame(int'(l), int'(r));
                prev_l = l;
                prev_r = r;
            end
        end
    endtask

    initial
    begin
        smp.valid        <= 1'b0;
        smp.left_sample  <= '0;
        smp.right_sample <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_STEP_RATIO;
        cfg_ch.data      <= '0;
        rst_n            <= 1'b0;

        // Bench state matches the block right after reset.
        for (int i = 0; i < HIST_FRAMES; i++)
        begin
            hist_l[i] = '0;
            hist_r[i] = '0;
        end
        pos_frac   = '0;
        lag        = '0;
        past_start = 1'b0;
        step_reg   = STEP_W'(STEP_RESET);
        chan_reg   = CH_W'(CH_RESET);
        prev_l     = '0;
        prev_r     = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_start_of_stream();
        test_step_extremes();
        test_clamped_config();
        test_random_streams();
        drain();

        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
